/* hw/rtl/tle_pkg.sv */
// Package for the tour length evaluator: field widths, opcodes, item structs
// and square root sizing. It depends on nothing else.
package tle_pkg;

  localparam int MAX_CITIES_DEF = 256;
  localparam int INDEX_W        = 8;
  localparam int COORD_W        = 16;
  localparam int TOTAL_W        = 32;

  // The sum of two 32-bit squares stays below 2^34, and the root's test bit
  // starts at 2^34, so the root datapath is 35 bits wide.
  localparam int ROOT_W     = 35;
  localparam int ROOT_STEPS = 18;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TOUR  = 1'b1;

  typedef struct packed {
    logic                 opcode;
    logic [INDEX_W-1:0]   city_index;
    logic [COORD_W-1:0]   x_coord;
    logic [COORD_W-1:0]   y_coord;
    logic                 last_city;
  } city_item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] tour_length;
  } total_item_t;

endpackage

/* hw/rtl/tle_if.sv */
// Valid/ready channels for the tour length evaluator: the city item input and
// the tour length output. Depends on tle_pkg.
interface tle_city_if (input logic clk);
  logic                   valid;
  logic                   ready;
  tle_pkg::city_item_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tle_total_if (input logic clk);
  logic                   valid;
  logic                   ready;
  tle_pkg::total_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/tour_length_evaluator.sv */
// A write item or the first city of a tour leaves the sequencer idle; a later tour city runs
// two table reads, two squares on one multiplier, 18 root steps and one add before it is idle.
// The last city of a longer tour then also runs the closing leg back to the first city, and a
// one-city tour goes straight to loading the output register; any wait for it to empty delays both.
// The shared root unit sets the rate, and the input is taken only while the sequencer is idle.
// Synchronous active-high reset clears the sequencer, tour state and output valid; the city
// table is not cleared and holds garbage until written. Depends on tle_pkg and tle_if.
module tour_length_evaluator #(
  parameter int MAX_CITIES = tle_pkg::MAX_CITIES_DEF
) (
  input logic               clk,
  input logic               rst,
  tle_city_if.sink          city,
  tle_total_if.source       total
);

  localparam int ADDR_W = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int IW     = tle_pkg::INDEX_W;
  localparam int CW     = tle_pkg::COORD_W;
  localparam int TW     = tle_pkg::TOTAL_W;
  localparam int RW     = tle_pkg::ROOT_W;
  localparam int STEP_W = $clog2(tle_pkg::ROOT_STEPS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD_A = 4'd1;
  localparam logic [3:0] S_RD_B = 4'd2;
  localparam logic [3:0] S_DIFF = 4'd3;
  localparam logic [3:0] S_SQX  = 4'd4;
  localparam logic [3:0] S_SQY  = 4'd5;
  localparam logic [3:0] S_ROOT = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  function automatic logic in_table(input logic [IW-1:0] idx);
    return 32'(idx) < 32'(MAX_CITIES);
  endfunction

  logic [3:0]            state;
  logic                  tour_active;
  logic [IW-1:0]         first_city;
  logic [IW-1:0]         previous_city;
  logic [TW-1:0]         running_total;
  logic [IW-1:0]         leg_a;
  logic [IW-1:0]         leg_b;
  logic                  last_pend;
  logic                  closing;

  logic [2*CW-1:0]       city_coords [MAX_CITIES];
  logic [2*CW-1:0]       mem_q;
  logic                  rd_ok;
  logic [IW-1:0]         rd_idx;
  logic [2*CW-1:0]       coord_a;
  logic [2*CW-1:0]       coord_b;

  logic [CW-1:0]         dx;
  logic [CW-1:0]         dy;
  logic [CW-1:0]         mul_op;
  logic [2*CW-1:0]       prod;

  logic [RW-1:0]         rad;
  logic [RW-1:0]         root;
  logic [RW-1:0]         test_bit;
  logic [STEP_W-1:0]     step;
  logic [RW:0]           trial;
  logic                  take;

  logic [TW:0]           sum;
  logic [TW-1:0]         sum_sat;

  logic                  out_valid;
  logic [TW-1:0]         out_len;
  logic                  accept;
  logic                  load_out;

  assign city.ready  = (state == S_IDLE);
  assign accept      = city.valid && city.ready;
  assign total.valid = out_valid;
  assign total.data.tour_length = out_len;

  // The output register is loaded once the finished total has a free slot.
  assign load_out = (state == S_EMIT) && (!out_valid || total.ready);

  // Table: one write port from the input, one registered read port.
  assign rd_idx = (state == S_RD_A) ? leg_a : leg_b;

  always_ff @(posedge clk) begin
    if (accept && city.data.opcode == tle_pkg::OP_WRITE && in_table(city.data.city_index)) begin
      city_coords[ADDR_W'(city.data.city_index)] <= {city.data.y_coord, city.data.x_coord};
    end
    mem_q <= city_coords[ADDR_W'(rd_idx)];
    rd_ok <= in_table(rd_idx);
  end

  // Entries beyond the table read as the origin.
  assign coord_b = rd_ok ? mem_q : '0;

  // One multiplier, used for dx squared and then dy squared.
  assign mul_op = (state == S_SQX) ? dx : dy;
  assign prod   = mul_op * mul_op;

  // One restoring square root step per cycle.
  assign trial = {1'b0, root} + {1'b0, test_bit};
  assign take  = ({1'b0, rad} >= trial);

  assign sum     = {1'b0, running_total} + {1'b0, TW'(root)};
  assign sum_sat = sum[TW] ? '1 : sum[TW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      tour_active   <= 1'b0;
      first_city    <= '0;
      previous_city <= '0;
      running_total <= '0;
      last_pend     <= 1'b0;
      closing       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (total.valid && total.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && city.data.opcode == tle_pkg::OP_TOUR) begin
            if (!tour_active) begin
              first_city    <= city.data.city_index;
              previous_city <= city.data.city_index;
              running_total <= '0;
              if (city.data.last_city) begin
                state <= S_EMIT;
              end else begin
                tour_active <= 1'b1;
              end
            end else begin
              leg_a         <= previous_city;
              leg_b         <= city.data.city_index;
              previous_city <= city.data.city_index;
              last_pend     <= city.data.last_city;
              closing       <= 1'b0;
              state         <= S_RD_A;
            end
          end
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: begin
          coord_a <= coord_b;
          state   <= S_DIFF;
        end
        S_DIFF: begin
          dx <= (coord_a[CW-1:0] > coord_b[CW-1:0]) ? coord_a[CW-1:0] - coord_b[CW-1:0]
                                                    : coord_b[CW-1:0] - coord_a[CW-1:0];
          dy <= (coord_a[2*CW-1:CW] > coord_b[2*CW-1:CW])
                  ? coord_a[2*CW-1:CW] - coord_b[2*CW-1:CW]
                  : coord_b[2*CW-1:CW] - coord_a[2*CW-1:CW];
          state <= S_SQX;
        end
        S_SQX: begin
          rad   <= RW'(prod);
          state <= S_SQY;
        end
        S_SQY: begin
          rad      <= rad + RW'(prod);
          root     <= '0;
          test_bit <= RW'(1) << (RW - 1);
          step     <= STEP_W'(tle_pkg::ROOT_STEPS - 1);
          state    <= S_ROOT;
        end
        S_ROOT: begin
          if (take) begin
            rad  <= rad - trial[RW-1:0];
            root <= (root >> 1) + test_bit;
          end else begin
            root <= root >> 1;
          end
          test_bit <= test_bit >> 2;
          step     <= step - STEP_W'(1);
          if (step == '0) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          running_total <= sum_sat;
          if (!last_pend) begin
            state <= S_IDLE;
          end else if (closing) begin
            state <= S_EMIT;
          end else begin
            // Closing leg from the last city back to the first one.
            closing <= 1'b1;
            leg_a   <= leg_b;
            leg_b   <= first_city;
            state   <= S_RD_A;
          end
        end
        S_EMIT: begin
          if (load_out) begin
            out_len     <= running_total;
            tour_active <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/tle_checker.sv */
// Port-level checks for the tour length evaluator, bound to the top level.
// Depends on tle_pkg and on tour_length_evaluator for the bind target.
module tle_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           city_valid,
  input logic                           city_ready,
  input logic                           city_opcode,
  input logic                           city_last,
  input logic                           total_valid,
  input logic                           total_ready,
  input logic [tle_pkg::TOTAL_W-1:0]    tour_length
);

  // A table write never stalls the next item.
  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (city_valid && city_ready && city_opcode == tle_pkg::OP_WRITE) |=> city_ready)
    else $error("input not ready after a table write");

  // The last city of a tour always produces work before the next item.
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (city_valid && city_ready && city_opcode == tle_pkg::OP_TOUR && city_last)
      |=> !city_ready)
    else $error("input ready right after the last city of a tour");

  // A new result is only loaded while the input side is busy.
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(total_valid) |-> $past(!city_ready))
    else $error("result appeared while the block was idle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (total_valid && !total_ready) |=> total_valid)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (total_valid && !total_ready) |=> $stable(tour_length))
    else $error("result changed while stalled");

endmodule

bind tour_length_evaluator tle_checker u_tle_checker (
  .clk         (clk),
  .rst         (rst),
  .city_valid  (city.valid),
  .city_ready  (city.ready),
  .city_opcode (city.data.opcode),
  .city_last   (city.data.last_city),
  .total_valid (total.valid),
  .total_ready (total.ready),
  .tour_length (total.data.tour_length)
);
